@@ sv/perspective_project_to_screen_defines.svh @@
// Assertion macros for the projection block
`ifndef PERSPECTIVE_PROJECT_TO_SCREEN_DEFINES_SVH
`define PERSPECTIVE_PROJECT_TO_SCREEN_DEFINES_SVH
`ifndef SYNTHESIS
`define PPS_ASSERT_IMP(name, clk, rstn, a, b) \
	name: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
		else $error("pps assertion failed");
`define PPS_ASSERT_NXT(name, clk, rstn, a, b) \
	name: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
		else $error("pps assertion failed");
`else
`define PPS_ASSERT_IMP(name, clk, rstn, a, b)
`define PPS_ASSERT_NXT(name, clk, rstn, a, b)
`endif
`endif

@@ sv/pps_pkg.sv @@
`timescale 1ns / 1ps
package pps_pkg;
	// clip sums, Q16.16 with headroom
	localparam int SW = 50;
	// scaled numerator, signed
	localparam int NW = 70;
	// divider remainder, unsigned
	localparam int RW = NW - 1;
	// divisor 2W
	localparam int DW = SW;
	// quotient bits, offset by 2^(QB-1)
	localparam int QB = 18;
	// placement arithmetic
	localparam int BW = 20;

	localparam logic signed [SW-1:0] W_MIN = SW'(655);

	typedef enum logic [3:0] {
		REG_R0_01  = 4'd0,
		REG_R0_23  = 4'd1,
		REG_R1_01  = 4'd2,
		REG_R1_23  = 4'd3,
		REG_R3_01  = 4'd4,
		REG_R3_23  = 4'd5,
		REG_WIDTH  = 4'd6,
		REG_HEIGHT = 4'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [5:0][63:0] coef;
		logic [14:0]      width;
		logic [14:0]      height;
	} mat_cfg_t;

	typedef struct packed {
		logic vis;
		logic x_lo;
		logic x_hi;
		logic y_lo;
		logic y_hi;
	} div_ctl_t;

	function automatic logic signed [15:0] sat16(logic signed [BW-1:0] v);
		logic signed [15:0] r;
		if (v > BW'(32767)) begin
			r = 16'sh7fff;
		end else if (v < -BW'(32768)) begin
			r = -16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction
endpackage

@@ sv/pps_point_if.sv @@
`timescale 1ns / 1ps
interface pps_point_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	modport source (output valid, point_x, point_y, point_z, input ready);
	modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

@@ sv/pps_pixel_if.sv @@
`timescale 1ns / 1ps
interface pps_pixel_if;
	logic               valid;
	logic               ready;
	logic               visible;
	logic signed [15:0] pixel_x;
	logic signed [15:0] pixel_y;
	modport source (output valid, visible, pixel_x, pixel_y, input ready);
	modport sink (input valid, visible, pixel_x, pixel_y, output ready);
endinterface

@@ sv/pps_cfg_if.sv @@
`timescale 1ns / 1ps
interface pps_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ sv/pps_front.sv @@
`timescale 1ns / 1ps
module pps_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pps_pkg::mat_cfg_t          mat_cfg,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [31:0]         in_x,
	input  logic signed [31:0]         in_y,
	input  logic signed [31:0]         in_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pps_pkg::RW-1:0]     out_rem_x,
	output logic [pps_pkg::RW-1:0]     out_rem_y,
	output logic [pps_pkg::DW-1:0]     out_d,
	output pps_pkg::div_ctl_t          out_ctl
);
	import pps_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;
	logic signed [31:0]   pt [3];
	logic signed [63:0]   mul [3][3];
	logic signed [47:0]   prod_s1 [3][3];
	logic signed [SW-1:0] sum_s2 [3];
	logic signed [65:0]   mx, my;
	logic signed [NW-1:0] nx_s3, ny_s3;
	logic signed [SW-1:0] w_s3, w_s4;
	logic                 vis_s3, vis_s4;
	logic signed [NW-1:0] npx_s4, npy_s4, lim;
	logic [RW-1:0]        remx_s5, remy_s5;
	logic [DW-1:0]        d_s5;
	div_ctl_t             ctl_s5;

	// advance a stage when it is empty or the next one moves
	assign en5 = !v_s5 || out_ready;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// coefficient times coordinate, rows X, Y, W
	always_comb begin
		pt[0] = in_x;
		pt[1] = in_y;
		pt[2] = in_z;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				mul[r][c] = $signed(mat_cfg.coef[2*r + ((c == 2) ? 1 : 0)]
					[((c == 1) ? 32 : 0) +: 32]) * pt[c];
			end
		end
	end

	// round products down to Q16.16
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= mul[r][c][63:16];
				end
			end
		end
	end

	// add the row with its translation term
	always_ff @(posedge clk) begin
		if (en2) begin
			for (int r = 0; r < 3; r++) begin
				sum_s2[r] <= SW'(prod_s1[r][0]) + SW'(prod_s1[r][1]) + SW'(prod_s1[r][2])
					+ SW'($signed(mat_cfg.coef[2*r + 1][63:32]));
			end
		end
	end

	// scale by the viewport size and add W
	assign mx = sum_s2[0] * $signed({1'b0, mat_cfg.width});
	assign my = sum_s2[1] * $signed({1'b0, mat_cfg.height});

	always_ff @(posedge clk) begin
		if (en3) begin
			nx_s3  <= NW'(mx) + NW'(sum_s2[2]);
			ny_s3  <= NW'(my) + NW'(sum_s2[2]);
			w_s3   <= sum_s2[2];
			vis_s3 <= (sum_s2[2] >= W_MIN);
		end
	end

	// offset the numerator so the quotient range starts at zero
	always_ff @(posedge clk) begin
		if (en4) begin
			npx_s4 <= nx_s3 + (NW'(w_s3) <<< QB);
			npy_s4 <= ny_s3 + (NW'(w_s3) <<< QB);
			w_s4   <= w_s3;
			vis_s4 <= vis_s3;
		end
	end

	// flag quotients that land outside the divider range
	assign lim = NW'(w_s4) <<< (QB + 1);

	always_ff @(posedge clk) begin
		if (en5) begin
			remx_s5     <= npx_s4[RW-1:0];
			remy_s5     <= npy_s4[RW-1:0];
			d_s5        <= {w_s4[SW-2:0], 1'b0};
			ctl_s5.vis  <= vis_s4;
			ctl_s5.x_lo <= npx_s4[NW-1];
			ctl_s5.x_hi <= (npx_s4 >= lim);
			ctl_s5.y_lo <= npy_s4[NW-1];
			ctl_s5.y_hi <= (npy_s4 >= lim);
		end
	end

	assign out_valid = v_s5;
	assign out_rem_x = remx_s5;
	assign out_rem_y = remy_s5;
	assign out_d     = d_s5;
	assign out_ctl   = ctl_s5;
endmodule

@@ sv/pps_div.sv @@
`timescale 1ns / 1ps
module pps_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [pps_pkg::RW-1:0]     in_rem_x,
	input  logic [pps_pkg::RW-1:0]     in_rem_y,
	input  logic [pps_pkg::DW-1:0]     in_d,
	input  pps_pkg::div_ctl_t          in_ctl,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [pps_pkg::QB-1:0]     out_q_x,
	output logic [pps_pkg::QB-1:0]     out_q_y,
	output logic                       out_nz_x,
	output logic                       out_nz_y,
	output pps_pkg::div_ctl_t          out_ctl
);
	import pps_pkg::*;

	// one quotient bit per stage, both lanes side by side
	logic          v_s   [QB];
	logic          en    [QB];
	logic [RW-1:0] rx_s  [QB];
	logic [RW-1:0] ry_s  [QB];
	logic [QB-1:0] qx_s  [QB];
	logic [QB-1:0] qy_s  [QB];
	logic [DW-1:0] d_s   [QB];
	div_ctl_t      ctl_s [QB];

	for (genvar k = 0; k < QB; k++) begin : g_st
		localparam int SH = QB - 1 - k;
		logic          v_in;
		logic [RW-1:0] rx_in, ry_in;
		logic [QB-1:0] qx_in, qy_in;
		logic [DW-1:0] d_in;
		div_ctl_t      c_in;
		logic [RW:0]   dsh, tx, ty;

		if (k == 0) begin : g_first
			assign v_in  = in_valid;
			assign rx_in = in_rem_x;
			assign ry_in = in_rem_y;
			assign qx_in = '0;
			assign qy_in = '0;
			assign d_in  = in_d;
			assign c_in  = in_ctl;
		end else begin : g_next
			assign v_in  = v_s[k-1];
			assign rx_in = rx_s[k-1];
			assign ry_in = ry_s[k-1];
			assign qx_in = qx_s[k-1];
			assign qy_in = qy_s[k-1];
			assign d_in  = d_s[k-1];
			assign c_in  = ctl_s[k-1];
		end

		if (k == QB - 1) begin : g_last
			assign en[k] = !v_s[k] || out_ready;
		end else begin : g_mid
			assign en[k] = !v_s[k] || en[k+1];
		end

		// trial subtract of the shifted divisor
		assign dsh = {1'b0, (RW'(d_in) << SH)};
		assign tx  = {1'b0, rx_in} - dsh;
		assign ty  = {1'b0, ry_in} - dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en[k]) begin
				v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rx_s[k]  <= tx[RW] ? rx_in : tx[RW-1:0];
				ry_s[k]  <= ty[RW] ? ry_in : ty[RW-1:0];
				qx_s[k]  <= {qx_in[QB-2:0], ~tx[RW]};
				qy_s[k]  <= {qy_in[QB-2:0], ~ty[RW]};
				d_s[k]   <= d_in;
				ctl_s[k] <= c_in;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_s[QB-1];
	assign out_q_x   = qx_s[QB-1];
	assign out_q_y   = qy_s[QB-1];
	assign out_nz_x  = |rx_s[QB-1];
	assign out_nz_y  = |ry_s[QB-1];
	assign out_ctl   = ctl_s[QB-1];
endmodule

@@ sv/perspective_project_to_screen.sv @@
// Pipeline: 5 front stages, 18 divider stages and 1 output stage;
// throughput one point per cycle unless the pixel output stalls.
// The 18-stage restoring divider, one quotient bit per stage, sets the depth.
// Reset (arst_n low, asynchronous) empties the pipeline and loads the identity
// rows and a 1920x1080 viewport.
`timescale 1ns / 1ps
`include "perspective_project_to_screen_defines.svh"
module perspective_project_to_screen (
	input logic        clk,
	input logic        arst_n,
	pps_point_if.sink  pt_in,
	pps_pixel_if.source px_out,
	pps_cfg_if.sink    cfg
);
	import pps_pkg::*;

	mat_cfg_t         mat_cfg;
	logic [5:0][63:0] coef_q;
	logic [14:0]      width_q, height_q;

	logic          f_valid, f_ready, d_valid, d_ready;
	logic [RW-1:0] f_rem_x, f_rem_y;
	logic [DW-1:0] f_d;
	div_ctl_t      f_ctl, d_ctl;
	logic [QB-1:0] q_x, q_y;
	logic          nz_x, nz_y;

	logic signed [BW-1:0] qxs, qys, hw, hh, bx, by;
	logic signed [15:0]   px, py;
	logic                 out_valid_q, vis_q;
	logic signed [15:0]   pixel_x_q, pixel_y_q;

	// register writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q   <= {64'd281474976710656, 64'd0, 64'd0, 64'd281474976710656,
				64'd0, 64'd65536};
			width_q  <= 15'd1920;
			height_q <= 15'd1080;
		end else if (cfg.valid) begin
			case (cfg_idx_t'(cfg.index))
				REG_R0_01:  coef_q[0] <= cfg.data;
				REG_R0_23:  coef_q[1] <= cfg.data;
				REG_R1_01:  coef_q[2] <= cfg.data;
				REG_R1_23:  coef_q[3] <= cfg.data;
				REG_R3_01:  coef_q[4] <= cfg.data;
				REG_R3_23:  coef_q[5] <= cfg.data;
				REG_WIDTH:  width_q <= cfg.data[14:0];
				REG_HEIGHT: height_q <= cfg.data[14:0];
				default: ;
			endcase
		end
	end

	assign mat_cfg.coef   = coef_q;
	assign mat_cfg.width  = width_q;
	assign mat_cfg.height = height_q;

	pps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat_cfg   (mat_cfg),
		.in_valid  (pt_in.valid),
		.in_ready  (pt_in.ready),
		.in_x      (pt_in.point_x),
		.in_y      (pt_in.point_y),
		.in_z      (pt_in.point_z),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_rem_x (f_rem_x),
		.out_rem_y (f_rem_y),
		.out_d     (f_d),
		.out_ctl   (f_ctl)
	);

	pps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_rem_x  (f_rem_x),
		.in_rem_y  (f_rem_y),
		.in_d      (f_d),
		.in_ctl    (f_ctl),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_q_x   (q_x),
		.out_q_y   (q_y),
		.out_nz_x  (nz_x),
		.out_nz_y  (nz_y),
		.out_ctl   (d_ctl)
	);

	// remove the quotient offset and place on screen, truncating toward zero
	assign qxs = BW'($signed({~q_x[QB-1], q_x[QB-2:0]}));
	assign qys = BW'($signed({~q_y[QB-1], q_y[QB-2:0]}));
	assign hw  = $signed(BW'(width_q[14:1]));
	assign hh  = $signed(BW'(height_q[14:1]));

	always_comb begin
		bx = hw + qxs;
		if (bx < 0 && nz_x) begin
			bx = bx + BW'(1);
		end
		by = hh - qys;
		if (by >= BW'(1) && nz_y) begin
			by = by - BW'(1);
		end
		if (d_ctl.x_lo) begin
			px = -16'sh8000;
		end else if (d_ctl.x_hi) begin
			px = 16'sh7fff;
		end else begin
			px = sat16(bx);
		end
		if (d_ctl.y_lo) begin
			py = 16'sh7fff;
		end else if (d_ctl.y_hi) begin
			py = -16'sh8000;
		end else begin
			py = sat16(by);
		end
	end

	// output register
	assign d_ready = !out_valid_q || px_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (d_ready) begin
			out_valid_q <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (d_ready) begin
			vis_q     <= d_ctl.vis;
			pixel_x_q <= d_ctl.vis ? px : 16'sd0;
			pixel_y_q <= d_ctl.vis ? py : 16'sd0;
		end
	end

	assign px_out.valid   = out_valid_q;
	assign px_out.visible = vis_q;
	assign px_out.pixel_x = pixel_x_q;
	assign px_out.pixel_y = pixel_y_q;

	`PPS_ASSERT_IMP(a_hidden_zero, clk, arst_n, px_out.valid && !px_out.visible, px_out.pixel_x == 16'sd0 && px_out.pixel_y == 16'sd0)
	`PPS_ASSERT_IMP(a_stall_from_out, clk, arst_n, !pt_in.ready, px_out.valid && !px_out.ready)
	`PPS_ASSERT_NXT(a_out_holds, clk, arst_n, px_out.valid && !px_out.ready && !pt_in.ready, px_out.valid)
endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
	import pps_pkg::*;

	typedef struct {
		logic        visible;
		logic [15:0] pixel_x;
		logic [15:0] pixel_y;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pps_point_if pt();
	pps_pixel_if px();
	pps_cfg_if   cf();

	perspective_project_to_screen u_top (
		.clk(clk), .arst_n(arst_n), .pt_in(pt.sink), .px_out(px.source), .cfg(cf.sink)
	);

	always #6 clk = ~clk;

	// predictor copy of the register file
	logic [63:0] mat_row [0:5];
	logic [14:0] vp_width, vp_height;
	pixel_t      pending_pixels[$];
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          mismatch_count = 0;
	int          points_sent = 0;
	int          pixels_checked = 0;
	int          visible_seen = 0;
	longint      cycle_count = 0;

	initial begin
		pt.valid = 1'b0;
		pt.point_x = '0;
		pt.point_y = '0;
		pt.point_z = '0;
		px.ready = 1'b0;
		cf.valid = 1'b0;
		cf.index = '0;
		cf.data = '0;
	end

	function automatic longint coef(int r, int c);
		logic [63:0] v;
		v = mat_row[r * 2 + c / 2];
		return (c % 2) ? longint'($signed(v[63:32])) : longint'($signed(v[31:0]));
	endfunction

	// product rounded down to Q16.16
	function automatic longint mul_floor(longint a, longint b);
		longint p, q;
		p = a * b;
		q = p / 65536;
		if (p % 65536 < 0)
			q = q - 1;
		return q;
	endfunction

	function automatic longint clip_sum(int r, longint x, longint y, longint z);
		return mul_floor(coef(r, 0), x) + mul_floor(coef(r, 1), y)
			+ mul_floor(coef(r, 2), z) + coef(r, 3);
	endfunction

	function automatic logic [15:0] place_pixel(longint half, longint n, longint d, bit neg);
		longint q, r, b;
		q = n / d;
		r = n % d;
		if (r < 0) begin
			q = q - 1;
			r = r + d;
		end
		if (!neg) begin
			b = half + q;
			if (b < 0 && r > 0)
				b = b + 1;
		end else begin
			b = half - q;
			if (b >= 1 && r > 0)
				b = b - 1;
		end
		if (b > 32767)
			b = 32767;
		if (b < -32768)
			b = -32768;
		return b[15:0];
	endfunction

	function automatic pixel_t project_point(logic [31:0] xi, logic [31:0] yi, logic [31:0] zi);
		pixel_t res;
		longint x, y, z, w, cx, cy, wd, ht;
		x = $signed(xi);
		y = $signed(yi);
		z = $signed(zi);
		w = clip_sum(2, x, y, z);
		res = '{1'b0, 16'd0, 16'd0};
		if (w >= 655) begin
			cx = clip_sum(0, x, y, z);
			cy = clip_sum(1, x, y, z);
			wd = vp_width;
			ht = vp_height;
			res.visible = 1'b1;
			res.pixel_x = place_pixel(wd / 2, cx * wd + w, 2 * w, 1'b0);
			res.pixel_y = place_pixel(ht / 2, cy * ht + w, 2 * w, 1'b1);
		end
		return res;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
		mismatch_count++;
	endtask

	// cycle limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("simulation failed");
			$finish;
		end
	end

	// random receiver stalls
	always @(posedge clk)
		px.ready <= arst_n && ($urandom_range(99) >= recv_stall_pct);

	// check each result against the oldest expectation
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && px.valid && px.ready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				e = pending_pixels.pop_front();
				pixels_checked++;
				if (e.visible)
					visible_seen++;
				if (px.visible !== e.visible)
					report_mismatch("visible", px.visible, e.visible);
				if (px.pixel_x !== e.pixel_x)
					report_mismatch("pixel_x", $signed(px.pixel_x), $signed(e.pixel_x));
				if (px.pixel_y !== e.pixel_y)
					report_mismatch("pixel_y", $signed(px.pixel_y), $signed(e.pixel_y));
			end
		end
	end

	// write one register, then drop valid and leave the channel idle before returning
	task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
		cf.valid <= 1'b1;
		cf.index <= idx;
		cf.data <= val;
		do @(posedge clk); while (!cf.ready);
		cf.valid <= 1'b0;
		@(posedge clk);
		if (idx >= REG_WIDTH) begin
			if (idx == REG_WIDTH)
				vp_width = val[14:0];
			else
				vp_height = val[14:0];
		end else begin
			mat_row[idx] = val;
		end
	endtask

	// request one point; valid stays high across back-to-back points
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
		while ($urandom_range(99) < send_idle_pct) begin
			pt.valid <= 1'b0;
			@(posedge clk);
		end
		pt.valid <= 1'b1;
		pt.point_x <= x;
		pt.point_y <= y;
		pt.point_z <= z;
		do @(posedge clk); while (!pt.ready);
		pending_pixels.push_back(project_point(x, y, z));
		points_sent++;
	endtask

	task automatic drain_results();
		pt.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
			2: return {{16{1'b0}}, 16'h0} + $urandom_range(0, 32'h0040_0000);
			default: return $urandom_range(0, 32'h00ff_ffff) - 32'h0080_0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_coef();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
			default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
		endcase
	endfunction

	task automatic test_reset_setup();
		mat_row[0] = 64'd65536;
		mat_row[1] = 64'd0;
		mat_row[2] = 64'h0001_0000_0000_0000;
		mat_row[3] = 64'd0;
		mat_row[4] = 64'd0;
		mat_row[5] = 64'h0001_0000_0000_0000;
		vp_width = 15'd1920;
		vp_height = 15'd1080;
		send_point(32'h0001_0000, 32'h0002_0000, 32'h0);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
		send_point(32'h0, 32'h0, 32'h0);
		drain_results();
	endtask

	// w from point z: below, at and above the visibility threshold
	task automatic test_visibility_edge();
		write_reg(REG_R3_01, 64'd0);
		write_reg(REG_R3_23, {32'd0, 32'h0001_0000});
		write_reg(REG_WIDTH, 64'hffff_ffff_ffff_ffff);
		write_reg(REG_HEIGHT, 64'h4000);
		send_point(32'h0001_0000, 32'hffff_0000, 32'd654);
		send_point(32'h0001_0000, 32'hffff_0000, 32'd655);
		send_point(32'h0001_0000, 32'hffff_0000, 32'd656);
		send_point(32'h7fff_ffff, 32'h8000_0000, 32'd655);
		send_point(32'h8000_0000, 32'h7fff_ffff, 32'd700);
		send_point(32'h0, 32'h0, 32'hffff_ffff);
		send_point(32'h0, 32'h0, 32'h8000_0000);
		drain_results();
		write_reg(REG_WIDTH, 64'd0);
		write_reg(REG_HEIGHT, 64'd1);
		send_point(32'h0003_0000, 32'hfffd_0000, 32'h0001_0000);
		send_point(32'hfffd_8000, 32'h0002_8000, 32'h0002_0000);
		drain_results();
	endtask

	// extreme coefficients, saturating pixels
	task automatic test_extreme_matrix();
		write_reg(REG_R0_01, 64'h8000_0000_7fff_ffff);
		write_reg(REG_R0_23, 64'h7fff_ffff_8000_0000);
		write_reg(REG_R1_01, 64'h7fff_ffff_8000_0000);
		write_reg(REG_R1_23, 64'h8000_0000_7fff_ffff);
		write_reg(REG_R3_01, 64'h0000_0000_0000_0000);
		write_reg(REG_R3_23, 64'h7fff_ffff_0000_0000);
		write_reg(REG_WIDTH, 64'h4000);
		write_reg(REG_HEIGHT, 64'h7fff);
		send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h0000_0001, 32'hffff_ffff, 32'h0000_0001);
		drain_results();
	endtask

	// random matrices and points across sender idle and receiver stall phases
	task automatic test_random_points();
		int phase, n, idx;
		for (phase = 0; phase < 8; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			for (idx = 0; idx < 4; idx++)
				write_reg(cfg_idx_t'(idx), {rand_coef(), rand_coef()});
			write_reg(REG_R3_01, {rand_coef() >>> 4, rand_coef() >>> 4});
			write_reg(REG_R3_23, {32'h0000_8000 + $urandom_range(0, 32'h0008_0000),
				rand_coef()});
			write_reg(REG_WIDTH, (phase == 0) ? 64'd1 : {$urandom, $urandom});
			write_reg(REG_HEIGHT, (phase == 1) ? 64'h4000 : 64'($urandom_range(1, 16384)));
			for (n = 0; n < 50; n++)
				send_point(rand_coord(), rand_coord(), rand_coord());
			drain_results();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_setup();
		test_visibility_edge();
		test_extreme_matrix();
		test_random_points();
		$display("covered %0d points, %0d results checked, %0d visible",
			points_sent, pixels_checked, visible_seen);
		$display("config phases swept matrix extremes, viewport limits and idle mixes");
		if (mismatch_count == 0 && pending_pixels.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
